// ===== hw/rtl/lathe_revolution_tessellator_macros.svh =====
// Assertion macros used by the lathe_revolution_tessellator RTL.
`ifndef LATHE_REVOLUTION_TESSELLATOR_MACROS_SVH
`define LATHE_REVOLUTION_TESSELLATOR_MACROS_SVH

`ifndef SYNTHESIS
`define LRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrt assertion failed");
`define LRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrt assertion failed");
`else
`define LRT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/lrt_pkg.sv =====
`timescale 1ns / 1ps

package lrt_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int COEF_W     = 16;
	localparam int FRAC_BITS  = 14;
	localparam int PROD_W     = COORD_W + COEF_W;
	localparam int ACC_W      = PROD_W + 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COEF_W;

	localparam logic [CFG_IDX_W-1:0] REG_COS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN = 1'd1;

	localparam logic signed [COEF_W-1:0] COS_RESET = 16'sd16384;
	localparam logic signed [COEF_W-1:0] SIN_RESET = 16'sd0;

	localparam logic signed [ACC_W-1:0] ACC_HALF =
		{{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_CMAX =
		{{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_CMIN =
		{{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// round half up, drop fraction, clamp to coordinate range
	function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v + ACC_HALF) >>> FRAC_BITS;
		if (t > ACC_CMAX) begin
			round_sat = ACC_CMAX[COORD_W-1:0];
		end else if (t < ACC_CMIN) begin
			round_sat = ACC_CMIN[COORD_W-1:0];
		end else begin
			round_sat = t[COORD_W-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/lathe_revolution_tessellator.sv =====
`timescale 1ns / 1ps
// Lathe tessellator: surface of revolution about the X axis.
// Command channel: a transaction is taken when start is high and busy is low.
//   opcode 0 appends a point (first_point clears the polyline first); it
//   finishes in that cycle and busy stays low. Appends past capacity are dropped.
//   opcode 1 rotates every stored point by the configured angle, writes the
//   rotated points back and emits 2*n triangles; with fewer than two points it
//   does nothing and busy stays low.
// Result channel: each triangle is on the vertex ports for one cycle with
//   result_strobe high; last_triangle marks the final one. The receiver cannot
//   stall; results are registered and leave as they are produced.
// Sequence: per point one memory read, one start step and a run of the shared
//   multiply/accumulate unit (four products through one multiplier), then the
//   emit states: S_EMIT0 for the first point, S_EMIT1 and S_EMIT2 for each
//   middle point, S_EMIT1 to S_EMIT3 for the last. busy is high for the whole
//   segment; the last triangle leaves in the cycle after.
// Config: cfg_we writes cos_angle (index 0) or sin_angle (index 1); the user
//   must do so only while idle, unguarded by the block. Reset: polyline empty,
//   cos_angle = 1.0, sin_angle = 0; point memory holds no reset, needs none.
`include "lathe_revolution_tessellator_macros.svh"

module lathe_revolution_tessellator import lrt_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic                        first_point,
	input  logic signed [COORD_W-1:0]   point_x,
	input  logic signed [COORD_W-1:0]   point_y,
	input  logic signed [COORD_W-1:0]   point_z,
	output logic                        result_strobe,
	output logic signed [COORD_W-1:0]   vertex0_x,
	output logic signed [COORD_W-1:0]   vertex0_y,
	output logic signed [COORD_W-1:0]   vertex0_z,
	output logic signed [COORD_W-1:0]   vertex1_x,
	output logic signed [COORD_W-1:0]   vertex1_y,
	output logic signed [COORD_W-1:0]   vertex1_z,
	output logic signed [COORD_W-1:0]   vertex2_x,
	output logic signed [COORD_W-1:0]   vertex2_y,
	output logic signed [COORD_W-1:0]   vertex2_z,
	output logic                        last_triangle
);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_START, S_WAIT, S_EMIT0, S_EMIT1, S_EMIT2, S_EMIT3
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         held_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [COEF_W-1:0] cos_q, sin_q;
	point_t                   mem [MAX_POINTS];
	point_t                   rd_q;
	point_t                   cur_o_q, cur_r_q, prev_o_q, prev_r_q;
	point_t                   v0_q, v1_q, v2_q;
	logic                     strobe_q, last_q;

	logic                      take, app_ok, is_last, rot_start, rot_done;
	logic [CNT_W-1:0]          app_cnt;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_waddr;
	point_t                    mem_wdata, rot_pt, cur_axis;
	logic signed [COORD_W-1:0] rot_y, rot_z;

	assign take      = start && (state_q == S_IDLE);
	assign app_cnt   = first_point ? '0 : held_q;
	assign app_ok    = take && !opcode && (app_cnt < CNT_W'(MAX_POINTS));
	assign is_last   = (CNT_W'(idx_q) + CNT_W'(1)) == held_q;
	assign rot_start = (state_q == S_START);
	assign rot_pt    = '{x: rd_q.x, y: rot_y, z: rot_z};
	assign cur_axis  = '{x: cur_o_q.x, y: '0, z: '0};

	assign mem_we    = app_ok || ((state_q == S_WAIT) && rot_done);
	assign mem_waddr = (state_q == S_WAIT) ? idx_q : app_cnt[IDX_W-1:0];
	assign mem_wdata = (state_q == S_WAIT) ? rot_pt :
		point_t'{x: point_x, y: point_y, z: point_z};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[idx_q];
	end

	lrt_rot u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.y_in   (rd_q.y),
		.z_in   (rd_q.z),
		.cos_in (cos_q),
		.sin_in (sin_q),
		.done   (rot_done),
		.y_out  (rot_y),
		.z_out  (rot_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RESET;
			sin_q <= SIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS: cos_q <= cfg_data;
				REG_SIN: sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			held_q   <= '0;
			idx_q    <= '0;
			cur_o_q  <= '0;
			cur_r_q  <= '0;
			prev_o_q <= '0;
			prev_r_q <= '0;
			v0_q     <= '0;
			v1_q     <= '0;
			v2_q     <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (!opcode) begin
							if (app_ok) begin
								held_q <= app_cnt + CNT_W'(1);
							end
						end else if (held_q >= CNT_W'(2)) begin
							idx_q   <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ:  state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (rot_done) begin
						prev_o_q <= cur_o_q;
						prev_r_q <= cur_r_q;
						cur_o_q  <= rd_q;
						cur_r_q  <= rot_pt;
						state_q  <= (idx_q == '0) ? S_EMIT0 : S_EMIT1;
					end
				end
				S_EMIT0: begin
					v0_q     <= cur_o_q;
					v1_q     <= cur_axis;
					v2_q     <= cur_r_q;
					strobe_q <= 1'b1;
					idx_q    <= idx_q + IDX_W'(1);
					state_q  <= S_READ;
				end
				S_EMIT1: begin
					v0_q     <= prev_o_q;
					v1_q     <= prev_r_q;
					v2_q     <= cur_o_q;
					strobe_q <= 1'b1;
					state_q  <= S_EMIT2;
				end
				S_EMIT2: begin
					v0_q     <= cur_o_q;
					v1_q     <= prev_r_q;
					v2_q     <= cur_r_q;
					strobe_q <= 1'b1;
					if (is_last) begin
						state_q <= S_EMIT3;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_EMIT3: begin
					v0_q     <= cur_o_q;
					v1_q     <= cur_r_q;
					v2_q     <= cur_axis;
					strobe_q <= 1'b1;
					last_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = strobe_q;
	assign last_triangle = last_q;
	assign vertex0_x     = v0_q.x;
	assign vertex0_y     = v0_q.y;
	assign vertex0_z     = v0_q.z;
	assign vertex1_x     = v1_q.x;
	assign vertex1_y     = v1_q.y;
	assign vertex1_z     = v1_q.z;
	assign vertex2_x     = v2_q.x;
	assign vertex2_y     = v2_q.y;
	assign vertex2_z     = v2_q.z;

	`LRT_ASSERT_IMP(a_held_range, clk, arst_n, 1'b1, held_q <= CNT_W'(MAX_POINTS))
	`LRT_ASSERT_IMP(a_rot_done_wait, clk, arst_n, rot_done, state_q == S_WAIT)
	`LRT_ASSERT_IMP(a_strobe_in_run, clk, arst_n, strobe_q, $past(state_q) != S_IDLE)
	`LRT_ASSERT_NXT(a_short_idle, clk, arst_n, take && opcode && (held_q < CNT_W'(2)), !busy)
	`LRT_ASSERT_NXT(a_last_ends, clk, arst_n, state_q == S_EMIT3, last_q && !busy)

endmodule

// ===== hw/rtl/lrt_rot.sv =====
`timescale 1ns / 1ps

module lrt_rot import lrt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] y_in,
	input  logic signed [COORD_W-1:0] z_in,
	input  logic signed [COEF_W-1:0]  cos_in,
	input  logic signed [COEF_W-1:0]  sin_in,
	output logic                      done,
	output logic signed [COORD_W-1:0] y_out,
	output logic signed [COORD_W-1:0] z_out
);

	typedef enum logic [2:0] {R_IDLE, R_M0, R_M1, R_M2, R_M3, R_M4} rstate_t;

	rstate_t                   state_q;
	logic signed [COORD_W-1:0] y_q, z_q, yo_q, zo_q;
	logic signed [COEF_W-1:0]  cos_q, sin_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_q;
	logic signed [COORD_W-1:0] op_a;
	logic signed [COEF_W-1:0]  op_b;

	// one shared multiplier: y*cos, z*sin, y*sin, z*cos
	always_comb begin
		case (state_q)
			R_M1: begin
				op_a = z_q;
				op_b = sin_q;
			end
			R_M2: begin
				op_a = y_q;
				op_b = sin_q;
			end
			R_M3: begin
				op_a = z_q;
				op_b = cos_q;
			end
			default: begin
				op_a = y_q;
				op_b = cos_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			y_q     <= '0;
			z_q     <= '0;
			cos_q   <= '0;
			sin_q   <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			yo_q    <= '0;
			zo_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			prod_q <= op_a * op_b;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						y_q     <= y_in;
						z_q     <= z_in;
						cos_q   <= cos_in;
						sin_q   <= sin_in;
						state_q <= R_M0;
					end
				end
				R_M0: state_q <= R_M1;
				R_M1: begin
					acc_q   <= ACC_W'(prod_q);
					state_q <= R_M2;
				end
				R_M2: begin
					yo_q    <= round_sat(acc_q - ACC_W'(prod_q));
					state_q <= R_M3;
				end
				R_M3: begin
					acc_q   <= ACC_W'(prod_q);
					state_q <= R_M4;
				end
				R_M4: begin
					zo_q    <= round_sat(acc_q + ACC_W'(prod_q));
					done_q  <= 1'b1;
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign y_out = yo_q;
	assign z_out = zo_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import lrt_pkg::*;

	typedef enum logic {
		OP_APPEND  = 1'b0,
		OP_SEGMENT = 1'b1
	} op_e;

	typedef struct packed {
		point_t v0;
		point_t v1;
		point_t v2;
		logic   last;
	} triangle_t;

	localparam int    ITEM_TARGET  = 380;
	localparam int    LIMIT_CYCLES = 400000;
	localparam int    DRAIN_CYCLES = 200;
	localparam int    IDLE_CYCLES  = 16;
	localparam longint COORD_MAX   = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_MIN   = -COORD_MAX - 1;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      start;
	logic                      busy;
	logic                      opcode;
	logic                      first_point;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      result_strobe;
	logic signed [COORD_W-1:0] vertex0_x;
	logic signed [COORD_W-1:0] vertex0_y;
	logic signed [COORD_W-1:0] vertex0_z;
	logic signed [COORD_W-1:0] vertex1_x;
	logic signed [COORD_W-1:0] vertex1_y;
	logic signed [COORD_W-1:0] vertex1_z;
	logic signed [COORD_W-1:0] vertex2_x;
	logic signed [COORD_W-1:0] vertex2_y;
	logic signed [COORD_W-1:0] vertex2_z;
	logic                      last_triangle;

	point_t                    polyline[MAX_POINTS];
	int unsigned               polyline_len;
	logic signed [COEF_W-1:0]  cos_coef;
	logic signed [COEF_W-1:0]  sin_coef;
	triangle_t                 pending_triangles[$];
	int                        fail_count  = 0;
	int                        item_count  = 0;
	int                        cycle_count = 0;
	bit                        no_idle     = 1'b0;

	lathe_revolution_tessellator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.first_point   (first_point),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.result_strobe (result_strobe),
		.vertex0_x     (vertex0_x),
		.vertex0_y     (vertex0_y),
		.vertex0_z     (vertex0_z),
		.vertex1_x     (vertex1_x),
		.vertex1_y     (vertex1_y),
		.vertex1_z     (vertex1_z),
		.vertex2_x     (vertex2_x),
		.vertex2_y     (vertex2_y),
		.vertex2_z     (vertex2_z),
		.last_triangle (last_triangle)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// round half up, floor, clamp to coordinate range
	function automatic logic signed [COORD_W-1:0] rotate_term(longint acc);
		longint t;
		t = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (t > COORD_MAX)
			t = COORD_MAX;
		else if (t < COORD_MIN)
			t = COORD_MIN;
		return COORD_W'(t);
	endfunction

	function automatic void apply_command(op_e op, logic first, point_t p);
		point_t rot[MAX_POINTS];
		point_t axis_head;
		point_t axis_tail;
		longint y;
		longint z;
		if (op == OP_APPEND) begin
			if (first)
				polyline_len = 0;
			if (polyline_len < MAX_POINTS) begin
				polyline[polyline_len] = p;
				polyline_len++;
			end
			return;
		end
		if (polyline_len < 2)
			return;
		for (int i = 0; i < polyline_len; i++) begin
			y        = longint'(polyline[i].y);
			z        = longint'(polyline[i].z);
			rot[i].x = polyline[i].x;
			rot[i].y = rotate_term(y * longint'(cos_coef) - z * longint'(sin_coef));
			rot[i].z = rotate_term(y * longint'(sin_coef) + z * longint'(cos_coef));
		end
		axis_head = '{x: polyline[0].x, y: '0, z: '0};
		axis_tail = '{x: polyline[polyline_len-1].x, y: '0, z: '0};
		pending_triangles.push_back('{polyline[0], axis_head, rot[0], 1'b0});
		for (int i = 0; i + 1 < polyline_len; i++) begin
			pending_triangles.push_back('{polyline[i], rot[i], polyline[i+1], 1'b0});
			pending_triangles.push_back('{polyline[i+1], rot[i], rot[i+1], 1'b0});
		end
		pending_triangles.push_back('{polyline[polyline_len-1], rot[polyline_len-1],
			axis_tail, 1'b1});
		for (int i = 0; i < polyline_len; i++)
			polyline[i] = rot[i];
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: return COORD_W'(COORD_MIN);
					1: return COORD_W'(COORD_MAX);
					2: return '0;
					default: return '1;
				endcase
			end
			1: return COORD_W'(int'($urandom_range(0, 200)) - 100);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.x = rand_coord();
		p.y = rand_coord();
		p.z = rand_coord();
		return p;
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		if ($urandom_range(0, 3) == 0)
			return COEF_W'($urandom);
		return COEF_W'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	task automatic check_field(string name, logic signed [COORD_W-1:0] want,
		logic signed [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		triangle_t want;
		if (arst_n && result_strobe === 1'b1) begin
			if (pending_triangles.size() == 0) begin
				$error("triangle transaction with none expected");
				fail_count++;
			end else begin
				want = pending_triangles.pop_front();
				check_field("vertex0_x", want.v0.x, vertex0_x);
				check_field("vertex0_y", want.v0.y, vertex0_y);
				check_field("vertex0_z", want.v0.z, vertex0_z);
				check_field("vertex1_x", want.v1.x, vertex1_x);
				check_field("vertex1_y", want.v1.y, vertex1_y);
				check_field("vertex1_z", want.v1.z, vertex1_z);
				check_field("vertex2_x", want.v2.x, vertex2_x);
				check_field("vertex2_y", want.v2.y, vertex2_y);
				check_field("vertex2_z", want.v2.z, vertex2_z);
				check_field("last_triangle", COORD_W'(want.last), COORD_W'(last_triangle));
			end
		end
	end

	task automatic send_command(op_e op, logic first, point_t p);
		int gap;
		bit counted;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       = 1'b1;
		opcode      = op;
		first_point = first;
		point_x     = p.x;
		point_y     = p.y;
		point_z     = p.z;
		do @(posedge clk); while (busy !== 1'b0);
		if (op == OP_APPEND)
			counted = first || polyline_len < MAX_POINTS;
		else
			counted = polyline_len >= 2;
		if (counted)
			item_count++;
		apply_command(op, first, p);
	endtask

	task automatic append_point(logic first, point_t p);
		send_command(OP_APPEND, first, p);
	endtask

	task automatic segment_item();
		send_command(OP_SEGMENT, 1'($urandom_range(0, 1)), rand_point());
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_triangles.size() != 0 || busy) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_COS)
			cos_coef = data;
		else
			sin_coef = data;
	endtask

	task automatic set_angle(logic signed [COEF_W-1:0] c, logic signed [COEF_W-1:0] s);
		wait_idle();
		write_reg(REG_COS, c);
		write_reg(REG_SIN, s);
	endtask

	task automatic run_polyline(int n, int segs);
		append_point(1'b1, rand_point());
		repeat (n - 1) append_point(1'b0, rand_point());
		repeat (segs) segment_item();
	endtask

	// empty and single-point polylines give no triangles
	task automatic test_short_polyline();
		segment_item();
		append_point(1'b1, '{x: 16'sd5, y: -16'sd7, z: 16'sd3});
		segment_item();
	endtask

	// exact halves must round toward plus infinity
	task automatic test_rounding();
		set_angle(16'sd8192, 16'sd8192);
		append_point(1'b1, '{x: 16'sd0, y: 16'sd1, z: 16'sd0});
		append_point(1'b0, '{x: -16'sd32768, y: -16'sd1, z: 16'sd0});
		segment_item();
	endtask

	// 16 points, four of them at the coordinate extremes, an overflow append, then a clear on full
	task automatic test_full_polyline();
		set_angle(16'sd16384, 16'sd16384);
		append_point(1'b1, '{x: -16'sd32768, y: 16'sd32767, z: 16'sd32767});
		append_point(1'b0, '{x: 16'sd32767, y: -16'sd32768, z: -16'sd32768});
		append_point(1'b0, '{x: 16'sd0, y: 16'sd32767, z: -16'sd32768});
		append_point(1'b0, '{x: -16'sd1, y: -16'sd32768, z: 16'sd32767});
		repeat (MAX_POINTS - 4) append_point(1'b0, rand_point());
		append_point(1'b0, rand_point());
		segment_item();
		append_point(1'b1, rand_point());
		append_point(1'b0, rand_point());
		segment_item();
	endtask

	task automatic test_coefficient_sweep();
		int cos_list[9] = '{0, -16384, 0, 11585, -16384, 32767, -32768, -16384, 16384};
		int sin_list[9] = '{16384, 0, -16384, 11585, -16384, -32768, 32767, 16384, 0};
		for (int i = 0; i < 9; i++) begin
			set_angle(COEF_W'(cos_list[i]), COEF_W'(sin_list[i]));
			run_polyline($urandom_range(2, 6), $urandom_range(1, 3));
		end
	endtask

	task automatic test_random_traffic();
		int n;
		while (item_count < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: set_angle(rand_coef(), rand_coef());
				1, 2, 3, 4, 5, 6: begin
					if ($urandom_range(0, 5) == 0)
						n = $urandom_range(2, MAX_POINTS + 2);
					else
						n = $urandom_range(2, 6);
					run_polyline(n, $urandom_range(1, 4));
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send_command(op_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							rand_point());
				end
			endcase
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_COS;
		cfg_data     = '0;
		opcode       = OP_APPEND;
		first_point  = 1'b0;
		point_x      = '0;
		point_y      = '0;
		point_z      = '0;
		polyline_len = 0;
		cos_coef     = COS_RESET;
		sin_coef     = SIN_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_short_polyline();
		test_rounding();
		test_full_polyline();
		test_coefficient_sweep();
		test_random_traffic();

		@(negedge clk);
		start = 1'b0;
		while (pending_triangles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lrt_pkg.sv
hw/rtl/lrt_rot.sv
hw/rtl/lathe_revolution_tessellator.sv
verif/tb.sv
